>>> hdl/ppg_pkg.sv
`default_nettype none

package ppg_pkg;

  // Geometry and table sizes
  localparam int GRID_SIZE       = 8;
  localparam int COORD_W         = 3;
  localparam int GRID_CELLS      = 1 << (2 * COORD_W);
  localparam int SINE_TABLE_BITS = 10;
  localparam int QTR_W           = SINE_TABLE_BITS - 2;
  localparam int QTR_SIZE        = 1 << QTR_W;
  localparam int PHASE_W         = 16;
  localparam int LANES           = 3;

  // Phase step arithmetic
  localparam int SPEED_W      = 8;
  localparam int DT_W         = 16;
  localparam int RATE_W       = 11;
  localparam int PROD_W       = DT_W + RATE_W;
  localparam int INV2PI_W     = 30;
  localparam int WIDE_W       = 56;
  localparam int MULW_W       = 60;
  localparam int XQ_W         = MULW_W - 32;
  localparam int RECIP_SHIFT  = 43;
  localparam int STEP_DIV     = 12750;
  localparam int RECIP_W      = 30;
  localparam int QPROD_W      = XQ_W + RECIP_W;
  localparam int Q_W          = QPROD_W - RECIP_SHIFT;
  localparam int RATE_BASE    = 255;

  localparam logic [INV2PI_W-1:0] INV2PI_Q32 = 30'd683565276;
  localparam logic [RECIP_W-1:0]  STEP_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / STEP_DIV);

  // Per-lane rate multipliers (tenths): t, 1.3t, 0.9t
  localparam logic [3:0] STEP_MULT [LANES] = '{4'd10, 4'd13, 4'd9};
  localparam int LANE_BASE   = 0;
  localparam int LANE_ROW    = 1;
  localparam int LANE_RADIAL = 2;

  // Offsets in Q0.24 turns
  localparam int COL_Q24  = 867807;
  localparam int ROW_Q24  = 734299;
  localparam int FACE_Q24 = 1869124;
  localparam int RAD_Q24  = 667544;

  // Sine polynomial in Q16
  localparam int unsigned SIN_C1 = 102944;
  localparam int unsigned SIN_C3 = 42334;
  localparam int unsigned SIN_C5 = 5223;
  localparam int unsigned SIN_C7 = 307;
  localparam int MAG_W      = 15;
  localparam int SINE_W     = 16;
  localparam int SUM_W      = 18;
  localparam int HUE_BIAS   = 98304;
  localparam int HUE_SHIFT  = 20;
  localparam int HUE_RECIP  = ((1 << HUE_SHIFT) + 2) / 3;
  localparam int HUE_PROD_W = SUM_W + 19;
  localparam int H6_W       = PHASE_W + 3;

  typedef enum logic [2:0] {
    SEG_RED_YELLOW   = 3'd0,
    SEG_YELLOW_GREEN = 3'd1,
    SEG_GREEN_CYAN   = 3'd2,
    SEG_CYAN_BLUE    = 3'd3,
    SEG_BLUE_MAGENTA = 3'd4,
    SEG_MAGENTA_RED  = 3'd5
  } hue_seg_t;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] face;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pix_tag_t;

  // Linear phase offset for a coordinate, in half cells from the center
  function automatic logic [PHASE_W-1:0] lin_offset(input logic [COORD_W-1:0] coord,
                                                   input int coef);
    int d;
    int v;
    d = 2 * int'(coord) - (GRID_SIZE - 1);
    v = d * coef + 128;
    return v[23:8];
  endfunction

  function automatic logic [PHASE_W-1:0] face_bias(input logic [COORD_W-1:0] face);
    int unsigned v;
    v = int'(face) * FACE_Q24 + 128;
    return v[23:8];
  endfunction

  // Radial phase offset: twice the center distance in Q8 times the radial rate
  function automatic logic [PHASE_W-1:0] rad_offset(input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row);
    int dx;
    int dy;
    int unsigned v;
    int unsigned res;
    int unsigned bt;
    longint unsigned t;
    dx  = 2 * int'(col) - (GRID_SIZE - 1);
    dy  = 2 * int'(row) - (GRID_SIZE - 1);
    v   = unsigned'(dx * dx + dy * dy) << 16;
    res = 0;
    bt  = 32'd1 << 30;
    for (int i = 0; i < 16; i++) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    t = 64'(res) * 64'(RAD_Q24) + 64'd32768;
    return t[31:16];
  endfunction

  // Quarter-wave sine magnitude in Q14 for quarter-wave step k
  function automatic logic [MAG_W-1:0] sine_mag(input int k);
    int unsigned x;
    int unsigned x2;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned s;
    longint unsigned t;
    x  = unsigned'(k) << (PHASE_W - SINE_TABLE_BITS);
    x2 = (x * x) >> 14;
    a  = SIN_C5 - ((x2 * SIN_C7) >> 14);
    b  = SIN_C3 - ((x2 * a) >> 14);
    c  = SIN_C1 - ((x2 * b) >> 14);
    t  = (64'(x) * 64'(c)) >> 16;
    s  = 32'(t);
    if (s > 32'd16384) s = 32'd16384;
    return MAG_W'(s);
  endfunction

  localparam logic [MAG_W-1:0] SINE_PEAK = sine_mag(QTR_SIZE);

endpackage

`default_nettype wire

>>> hdl/plasma_pattern_pixel_generator.sv
// Plasma pattern pixel generator.
//
// Input channel (in_valid / in_stall): one pixel request per item, with
// frame_start, time_step, face_index, column and row. An item is taken at a
// rising edge with in_valid high and in_stall low. An item with frame_start
// set first advances the three animation phases by time_step times the rate
// set by speed_setting; the pixel then uses the advanced phases.
// Output channel (out_valid / out_stall): one item per request, in request
// order, carrying face/column/row and the red, green, blue bytes.
// Configuration: cfg_write_en writes cfg_write_data into speed_setting at the
// edge; write only while no request is in flight.
// Pipeline: nine register stages, stages 1 to 8 and the output register.
// Throughput: one item per cycle while out_stall is low, set by the
// single-pass pipeline (no stage is reused).
// Stall: out_stall holds the output register; stages behind it keep filling
// bubbles, and in_stall rises only once every stage holds an item.
// Reset (rst, synchronous): empties the pipeline, clears the phases and sets
// speed_setting to 0.

`default_nettype none

module plasma_pattern_pixel_generator
  import ppg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic [SPEED_W-1:0] cfg_write_data,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               frame_start,
  input  wire logic [DT_W-1:0]    time_step,
  input  wire logic [COORD_W-1:0] face_index,
  input  wire logic [COORD_W-1:0] column,
  input  wire logic [COORD_W-1:0] row,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [COORD_W-1:0] out_face,
  output      logic [COORD_W-1:0] out_column,
  output      logic [COORD_W-1:0] out_row,
  output      logic [7:0]         red,
  output      logic [7:0]         green,
  output      logic [7:0]         blue
);

  localparam int STAGES = 8;

  // Constant tables, folded at elaboration
  logic [PHASE_W-1:0] col_tab  [1 << COORD_W];
  logic [PHASE_W-1:0] row_tab  [1 << COORD_W];
  logic [PHASE_W-1:0] face_tab [1 << COORD_W];
  logic [PHASE_W-1:0] rad_tab  [GRID_CELLS];
  logic [MAG_W-1:0]   sin_tab  [QTR_SIZE];

  for (genvar gi = 0; gi < (1 << COORD_W); gi++) begin : g_lin_tab
    assign col_tab[gi]  = lin_offset(COORD_W'(gi), COL_Q24);
    assign row_tab[gi]  = lin_offset(COORD_W'(gi), ROW_Q24);
    assign face_tab[gi] = face_bias(COORD_W'(gi));
  end

  for (genvar gi = 0; gi < GRID_CELLS; gi++) begin : g_rad_tab
    assign rad_tab[gi] = rad_offset(COORD_W'(gi), COORD_W'(gi >> COORD_W));
  end

  for (genvar gi = 0; gi < QTR_SIZE; gi++) begin : g_sin_tab
    assign sin_tab[gi] = sine_mag(gi);
  end

  // Configuration and animation state
  logic [SPEED_W-1:0] speed_setting;
  logic [PHASE_W-1:0] phase_base;
  logic [PHASE_W-1:0] phase_row_term;
  logic [PHASE_W-1:0] phase_radial_term;

  // Pipeline occupancy and load enables; stage i loads when empty or draining
  logic [STAGES:1]   vld;
  logic [STAGES+1:1] load;
  pix_tag_t          tag [1:STAGES];

  always_comb begin
    load[STAGES+1] = !out_valid || !out_stall;
    for (int i = STAGES; i >= 1; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign in_stall = !load[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load[1]) vld[1] <= in_valid;
      for (int i = 2; i <= STAGES; i++) begin
        if (load[i]) vld[i] <= vld[i-1];
      end
      if (load[STAGES+1]) out_valid <= vld[STAGES];
    end
  end

  // Carry the request tag down the pipe
  always_ff @(posedge clk) begin
    if (load[1]) tag[1] <= '{start: frame_start, face: face_index, col: column, row: row};
    for (int i = 2; i <= STAGES; i++) begin
      if (load[i]) tag[i] <= tag[i-1];
    end
  end

  // Stage 1: dt times the speed rate (255 + 4*speed)
  logic [RATE_W-1:0] rate_k;
  logic [PROD_W-1:0] s1_prod;

  assign rate_k = RATE_W'(RATE_BASE) + RATE_W'({speed_setting, 2'b00});

  always_ff @(posedge clk) begin
    if (load[1]) s1_prod <= PROD_W'(time_step) * PROD_W'(rate_k);
  end

  // Stage 2: scale by 1/(2*pi) in Q32
  logic [WIDE_W-1:0] s2_wide;

  always_ff @(posedge clk) begin
    if (load[2]) s2_wide <= WIDE_W'(s1_prod) * WIDE_W'(INV2PI_Q32);
  end

  // Stage 3: per-lane multiplier, drop the Q32 fraction
  logic [MULW_W-1:0] mulw [LANES];
  logic [XQ_W-1:0]   s3_xq [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mulw[l] = MULW_W'(s2_wide) * MULW_W'(STEP_MULT[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      for (int l = 0; l < LANES; l++) s3_xq[l] <= mulw[l][MULW_W-1:32];
    end
  end

  // Stage 4: quotient estimate by reciprocal, at most one short
  logic [QPROD_W-1:0] qprod [LANES];
  logic [Q_W-1:0]     s4_q0 [LANES];
  logic [XQ_W-1:0]    s4_xq [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qprod[l] = QPROD_W'(s3_xq[l]) * QPROD_W'(STEP_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      for (int l = 0; l < LANES; l++) begin
        s4_q0[l] <= qprod[l][QPROD_W-1:RECIP_SHIFT];
        s4_xq[l] <= s3_xq[l];
      end
    end
  end

  // Stage 5: correct the quotient with one compare
  logic [XQ_W-1:0]    rem [LANES];
  logic [PHASE_W-1:0] s5_inc [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[l] = s4_xq[l] - XQ_W'(s4_q0[l]) * XQ_W'(STEP_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      for (int l = 0; l < LANES; l++) begin
        s5_inc[l] <= PHASE_W'(s4_q0[l]) + PHASE_W'(rem[l] >= XQ_W'(STEP_DIV));
      end
    end
  end

  // Stage 6: advance the phases on a frame start, then form the three phases
  logic               phase_adv;
  logic [PHASE_W-1:0] base_next;
  logic [PHASE_W-1:0] row_next;
  logic [PHASE_W-1:0] radial_next;
  logic [PHASE_W-1:0] s6_ph [LANES];

  assign phase_adv   = vld[5] && load[6];
  assign base_next   = tag[5].start ? phase_base + s5_inc[LANE_BASE] : phase_base;
  assign row_next    = tag[5].start ? phase_row_term + s5_inc[LANE_ROW] : phase_row_term;
  assign radial_next = tag[5].start ? phase_radial_term + s5_inc[LANE_RADIAL]
                                    : phase_radial_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_setting     <= '0;
      phase_base        <= '0;
      phase_row_term    <= '0;
      phase_radial_term <= '0;
    end else begin
      if (cfg_write_en) speed_setting <= cfg_write_data;
      if (phase_adv) begin
        phase_base        <= base_next;
        phase_row_term    <= row_next;
        phase_radial_term <= radial_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      s6_ph[LANE_BASE]   <= base_next + col_tab[tag[5].col];
      s6_ph[LANE_ROW]    <= row_next + row_tab[tag[5].row] + face_tab[tag[5].face];
      s6_ph[LANE_RADIAL] <= rad_tab[{tag[5].row, tag[5].col}] - radial_next;
    end
  end

  // Stage 7: quarter-wave sine lookups
  logic [SINE_TABLE_BITS-1:0] sq   [LANES];
  logic [QTR_W-1:0]           sidx [LANES];
  logic [MAG_W-1:0]           smag [LANES];
  logic signed [SINE_W-1:0]   s7_sin [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sq[l]   = s6_ph[l][PHASE_W-1 -: SINE_TABLE_BITS];
      // odd quadrants mirror the quarter wave
      sidx[l] = sq[l][SINE_TABLE_BITS-2] ? QTR_W'(-sq[l][QTR_W-1:0]) : sq[l][QTR_W-1:0];
      if (sq[l][SINE_TABLE_BITS-2] && (sq[l][QTR_W-1:0] == '0)) begin
        smag[l] = SINE_PEAK;
      end else begin
        smag[l] = sin_tab[sidx[l]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[7]) begin
      for (int l = 0; l < LANES; l++) begin
        s7_sin[l] <= sq[l][SINE_TABLE_BITS-1] ? -$signed({1'b0, smag[l]})
                                               : $signed({1'b0, smag[l]});
      end
    end
  end

  // Stage 8: sum to hue, (2*S + 98304)/3 by reciprocal, wrap to one turn
  logic signed [SUM_W-1:0] sine_sum;
  logic [SUM_W-1:0]        hue_num;
  logic [HUE_PROD_W-1:0]   hue_prod;
  logic [PHASE_W-1:0]      s8_hue;

  assign sine_sum = SUM_W'(s7_sin[0]) + SUM_W'(s7_sin[1]) + SUM_W'(s7_sin[2]);
  assign hue_num  = SUM_W'(sine_sum <<< 1) + SUM_W'(HUE_BIAS);
  assign hue_prod = HUE_PROD_W'(hue_num) * HUE_PROD_W'(HUE_RECIP);

  always_ff @(posedge clk) begin
    if (load[8]) s8_hue <= hue_prod[HUE_SHIFT +: PHASE_W];
  end

  // Output stage: hue segment to full-saturation RGB
  logic [H6_W-1:0]    h6;
  logic [PHASE_W-1:0] frac;
  logic [23:0]        rise_prod;
  logic [23:0]        fall_prod;
  logic [7:0]         rise;
  logic [7:0]         fall;
  logic [7:0]         red_next;
  logic [7:0]         green_next;
  logic [7:0]         blue_next;

  always_comb begin
    h6        = H6_W'(s8_hue) * H6_W'(6);
    frac      = h6[PHASE_W-1:0];
    rise_prod = 24'(frac) * 24'd255;
    fall_prod = (24'h010000 - 24'(frac)) * 24'd255;
    rise      = rise_prod[23:16];
    fall      = fall_prod[23:16];
    unique case (hue_seg_t'(h6[H6_W-1:PHASE_W]))
      SEG_RED_YELLOW:   begin red_next = 8'd255; green_next = rise;   blue_next = 8'd0;   end
      SEG_YELLOW_GREEN: begin red_next = fall;   green_next = 8'd255; blue_next = 8'd0;   end
      SEG_GREEN_CYAN:   begin red_next = 8'd0;   green_next = 8'd255; blue_next = rise;   end
      SEG_CYAN_BLUE:    begin red_next = 8'd0;   green_next = fall;   blue_next = 8'd255; end
      SEG_BLUE_MAGENTA: begin red_next = rise;   green_next = 8'd0;   blue_next = 8'd255; end
      default:          begin red_next = 8'd255; green_next = 8'd0;   blue_next = fall;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load[STAGES+1]) begin
      out_face   <= tag[STAGES].face;
      out_column <= tag[STAGES].col;
      out_row    <= tag[STAGES].row;
      red        <= red_next;
      green      <= green_next;
      blue       <= blue_next;
    end
  end

`ifndef SYNTHESIS
  // An empty first stage must never push back on the sender
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[1] |-> !in_stall)
    else $error("in_stall high with empty input stage");

  // Phases move only when an item moves into the phase stage
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !phase_adv |=> ($stable(phase_base) && $stable(phase_row_term)
                    && $stable(phase_radial_term)))
    else $error("phase changed without an advancing item");

  // The output register loads only what the last stage holds
  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    (load[STAGES+1] && !vld[STAGES]) |=> !out_valid)
    else $error("out_valid set without an item in the last stage");

  // Full saturation and value: some channel is always at full scale
  a_full_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == 8'd255 || green == 8'd255 || blue == 8'd255))
    else $error("no channel at full scale");
`endif

endmodule

`default_nettype wire

>>> tb/sv/plasma_pattern_pixel_generator_tb.sv
`default_nettype none

// Self-checking bench for the plasma pattern pixel generator. A clocked driver
// feeds pixel requests from a queue, a clocked monitor compares every output
// item against a bit-exact color predictor run at the accepting edge.
module plasma_pattern_pixel_generator_tb;
  import ppg_pkg::*;

  // Fixed-point constants of the plasma math (Q0.24 turns, Q16 polynomial)
  localparam int          CELLS      = 8;
  localparam longint      COL_TURNS  = 867807;
  localparam longint      ROW_TURNS  = 734299;
  localparam int unsigned FACE_TURNS = 1869124;
  localparam longint unsigned RADIAL_TURNS = 667544;
  localparam longint unsigned RAD_PER_TURN = 683565276;
  localparam longint unsigned RATE_DIV = 64'd12750 << 32;
  localparam int unsigned POLY1 = 102944;
  localparam int unsigned POLY3 = 42334;
  localparam int unsigned POLY5 = 5223;
  localparam int unsigned POLY7 = 307;
  localparam int unsigned MULT_BASE   = 10;
  localparam int unsigned MULT_ROW    = 13;
  localparam int unsigned MULT_RADIAL = 9;

  typedef struct packed {
    logic               start;
    logic [DT_W-1:0]    dt;
    logic [COORD_W-1:0] face;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pixel_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] face;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pixel_rgb_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [SPEED_W-1:0] cfg_write_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               frame_start = 1'b0;
  logic [DT_W-1:0]    time_step = '0;
  logic [COORD_W-1:0] face_index = '0;
  logic [COORD_W-1:0] column = '0;
  logic [COORD_W-1:0] row = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COORD_W-1:0] out_face;
  logic [COORD_W-1:0] out_column;
  logic [COORD_W-1:0] out_row;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;

  plasma_pattern_pixel_generator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .frame_start   (frame_start),
    .time_step     (time_step),
    .face_index    (face_index),
    .column        (column),
    .row           (row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_face      (out_face),
    .out_column    (out_column),
    .out_row       (out_row),
    .red           (red),
    .green         (green),
    .blue          (blue)
  );

  always #1 clk = ~clk;

  // Predictor state: speed register and the three phase accumulators
  logic [SPEED_W-1:0] speed_model = '0;
  logic [15:0]        base_phase = '0;
  logic [15:0]        row_phase = '0;
  logic [15:0]        radial_phase = '0;

  pixel_req_t request_queue[$];
  pixel_rgb_t color_queue[$];
  pixel_req_t cur_req;
  int         gap_left = 0;
  int         stall_left = 0;
  int         mismatches = 0;
  bit         steady = 1'b0;  // set to run a phase with no idling on either side

  // Phase advance for one accumulator, truncated to one turn
  function automatic logic [15:0] phase_advance(logic [DT_W-1:0] dt, int unsigned mult);
    longint unsigned num;
    num = longint'(dt) * longint'(255 + 4 * int'(speed_model)) * longint'(mult) *
          RAD_PER_TURN;
    return 16'(num / RATE_DIV);
  endfunction

  // Linear phase offset for a coordinate measured from the grid center
  function automatic logic [15:0] lin_phase(logic [COORD_W-1:0] coord, longint coef);
    int          d;
    logic [31:0] v;
    d = 2 * int'(coord) - (CELLS - 1);
    v = 32'(longint'(d) * coef) + 32'd128;
    return v[23:8];
  endfunction

  function automatic int unsigned root_u32(int unsigned value);
    int unsigned v;
    int unsigned res;
    int unsigned bt;
    v   = value;
    res = 0;
    bt  = 32'd1 << 30;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Sine in Q14 from the top ten phase bits, quarter-wave folded polynomial
  function automatic int wave_q14(logic [15:0] ph);
    logic [15:0] q;
    int unsigned x;
    int unsigned x2;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned s;
    q = {ph[15:6], 6'd0};
    x = 32'(q[13:0]);
    if (q[14]) x = 16384 - x;
    x2 = (x * x) >> 14;
    a  = POLY5 - ((x2 * POLY7) >> 14);
    b  = POLY3 - ((x2 * a) >> 14);
    c  = POLY1 - ((x2 * b) >> 14);
    s  = 32'((longint'(x) * longint'(c)) >> 16);
    if (s > 16384) s = 16384;
    return q[15] ? -int'(s) : int'(s);
  endfunction

  // Advance the phases for a frame start, then shade one pixel
  function automatic pixel_rgb_t shade_pixel(pixel_req_t rq);
    pixel_rgb_t      px;
    int              dx;
    int              dy;
    int unsigned     dist2;
    longint unsigned rad;
    logic [31:0]     bias;
    logic [15:0]     p1;
    logic [15:0]     p2;
    logic [15:0]     p3;
    logic [15:0]     hue;
    logic [31:0]     h6;
    int unsigned     f;
    logic [7:0]      rise;
    logic [7:0]      fall;
    int              total;
    if (rq.start) begin
      base_phase   = base_phase + phase_advance(rq.dt, MULT_BASE);
      row_phase    = row_phase + phase_advance(rq.dt, MULT_ROW);
      radial_phase = radial_phase + phase_advance(rq.dt, MULT_RADIAL);
    end
    dx    = 2 * int'(rq.col) - (CELLS - 1);
    dy    = 2 * int'(rq.row) - (CELLS - 1);
    bias  = int'(rq.face) * FACE_TURNS + 32'd128;
    p1    = base_phase + lin_phase(rq.col, COL_TURNS);
    p2    = row_phase + lin_phase(rq.row, ROW_TURNS) + bias[23:8];
    dist2 = unsigned'(dx * dx + dy * dy) << 16;
    rad   = longint'(root_u32(dist2)) * RADIAL_TURNS + 64'd32768;
    p3    = rad[31:16] - radial_phase;
    total = wave_q14(p1) + wave_q14(p2) + wave_q14(p3);
    // Sum is never below -3 * 16384, so the division is a floor
    hue   = 16'((2 * total + 98304) / 3);
    h6    = 32'(hue) * 32'd6;
    f     = 32'(h6[15:0]);
    rise  = 8'((255 * f) >> 16);
    fall  = 8'((255 * (65536 - f)) >> 16);
    px.face = rq.face;
    px.col  = rq.col;
    px.row  = rq.row;
    case (hue_seg_t'(h6[18:16]))
      SEG_RED_YELLOW:   begin px.red = 8'd255; px.green = rise;   px.blue = 8'd0;   end
      SEG_YELLOW_GREEN: begin px.red = fall;   px.green = 8'd255; px.blue = 8'd0;   end
      SEG_GREEN_CYAN:   begin px.red = 8'd0;   px.green = 8'd255; px.blue = rise;   end
      SEG_CYAN_BLUE:    begin px.red = 8'd0;   px.green = fall;   px.blue = 8'd255; end
      SEG_BLUE_MAGENTA: begin px.red = rise;   px.green = 8'd0;   px.blue = 8'd255; end
      default:          begin px.red = 8'd255; px.green = 8'd0;   px.blue = fall;   end
    endcase
    return px;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: predict at the accepting edge, then present the next item after its gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) color_queue.push_back(shade_pixel(cur_req));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          cur_req = request_queue.pop_front();
          frame_start <= cur_req.start;
          time_step   <= cur_req.dt;
          face_index  <= cur_req.face;
          column      <= cur_req.col;
          row         <= cur_req.row;
          in_valid    <= 1'b1;
          gap_left = steady ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each output item with the oldest prediction, stall at random
  always @(posedge clk) begin
    pixel_rgb_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (color_queue.size() == 0) begin
          $display("%0t unexpected pixel face %0d col %0d row %0d", $time, out_face,
                   out_column, out_row);
          mismatches++;
        end else begin
          want = color_queue.pop_front();
          check_field("out_face", want.face, out_face);
          check_field("out_column", want.col, out_column);
          check_field("out_row", want.row, out_row);
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
        end
      end
      if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic queue_pixel(input logic start, input logic [DT_W-1:0] dt,
                             input int face, input int col, input int rw);
    pixel_req_t rq;
    rq.start = start;
    rq.dt    = dt;
    rq.face  = COORD_W'(face);
    rq.col   = COORD_W'(col);
    rq.row   = COORD_W'(rw);
    request_queue.push_back(rq);
  endtask

  function automatic logic [DT_W-1:0] pick_step();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return DT_W'($urandom_range(1, 255));
    return DT_W'($urandom);
  endfunction

  // Frames: a frame start with a step from pick_step, then pixels; a few stray frame starts
  task automatic queue_frames(input int count);
    int left;
    int len;
    int face;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 24);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        face = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
        if (i == 0) begin
          queue_pixel(1'b1, pick_step(), face, $urandom_range(0, 7), $urandom_range(0, 7));
        end else begin
          queue_pixel($urandom_range(0, 19) == 0, DT_W'($urandom), face,
                      $urandom_range(0, 7), $urandom_range(0, 7));
        end
      end
      left -= len;
    end
  endtask

  // Wait until every request is out and checked, then let the pipeline settle
  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || color_queue.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_speed(input logic [SPEED_W-1:0] value);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    speed_model = value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    logic [SPEED_W-1:0] speeds[7];
    speeds = '{8'd255, 8'd0, 8'd128, 8'd1, 8'd0, 8'd0, 8'd254};
    speeds[4] = SPEED_W'($urandom);
    speeds[5] = SPEED_W'($urandom);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every face including the two out of range, all four corners,
    // step extremes, stray steps with no frame start, and center pixels
    for (int f = 0; f < 8; f++) queue_pixel(f == 3, 16'h1234, f, f, 7 - f);
    queue_pixel(1'b1, 16'hFFFF, 0, 0, 0);
    queue_pixel(1'b1, 16'hFFFF, 5, 0, 7);
    queue_pixel(1'b1, 16'hFFFF, 6, 7, 0);
    queue_pixel(1'b1, 16'hFFFF, 7, 7, 7);
    queue_pixel(1'b1, 16'h0000, 2, 3, 4);
    queue_pixel(1'b0, 16'hFFFF, 1, 4, 3);
    queue_pixel(1'b1, 16'h0001, 4, 3, 3);
    queue_pixel(1'b1, 16'h8000, 3, 4, 4);
    queue_pixel(1'b1, 16'h5555, 1, 2, 5);
    queue_pixel(1'b1, 16'hAAAA, 4, 5, 2);
    wait_drained();

    // Random frames under several speeds; the third phase runs without idling
    for (int p = 0; p < 7; p++) begin
      write_speed(speeds[p]);
      @(negedge clk);
      steady = (p == 2);
      queue_frames(100);
      wait_drained();
    end
    steady = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatches == 0 && color_queue.size() == 0) begin
      $display("plasma_pattern_pixel_generator_tb OK");
    end else begin
      $display("plasma_pattern_pixel_generator_tb NOT OK");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #2000000;
    $display("plasma_pattern_pixel_generator_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
